// ===== rtl/pel_pkg.sv =====
// Package for the password entry lockout block.
// Holds character codes, result kinds, register indexes, reset values and shared types.
// No dependencies.
`default_nettype none

package pel_pkg;

	localparam int CNT_W = 4;
	localparam int FAIL_W = 4;
	localparam int PW_CHARS = 10;

	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_ENTER = 8'd13;
	localparam logic [7:0] CH_STAR = 8'd42;
	localparam logic [7:0] CH_NUL = 8'd0;

	localparam logic [FAIL_W-1:0] FAIL_SAT = 4'd15;

	localparam logic [63:0] PW_FIRST8_RST = 64'd125823019607414;
	localparam logic [15:0] PW_LAST2_RST = 16'd0;
	localparam logic [3:0] PW_LEN_RST = 4'd6;
	localparam logic [3:0] MAX_FAIL_RST = 4'd3;

	typedef enum logic [1:0] {
		REG_PW_FIRST8 = 2'd0,
		REG_PW_LAST2 = 2'd1,
		REG_PW_LEN = 2'd2,
		REG_MAX_FAIL = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2,
		KIND_LOCKED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_ENTERING = 2'd0,
		MODE_OPEN = 2'd1,
		MODE_LOCKED = 2'd2
	} mode_t;

	typedef struct packed {
		logic [63:0] pw_first8;
		logic [15:0] pw_last2;
		logic [3:0] pw_len;
		logic [3:0] max_fail;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] echo;
		logic [3:0] left;
		logic last;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/password_entry_lockout.sv =====
// Password entry lockout: keypad password lock with an attempt limit.
// Flow: a character is registered in the input stage, and once the result
// queue has room its results are written into the queue, whose head is presented.
// Throughput: one character per cycle while the result queue has room; a backspace
// yields two results and holds the input side until the queue is empty.
// Reset: asynchronous, active low; registers take their defaults, mode enters.
`default_nettype none

module password_entry_lockout #(
	parameter int MAX_LEN = 10
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic      [63:0]  prdata,
	output logic              pready,
	// character channel
	input  wire logic         rx_valid,
	output logic              rx_ready,
	input  wire logic [7:0]   rx_char,
	// result channel
	output logic              res_valid,
	input  wire logic         res_ready,
	output logic      [1:0]   result_kind,
	output logic      [7:0]   echo_char,
	output logic      [3:0]   attempts_left,
	output logic              last_of_run
);
	import pel_pkg::*;

	cfg_t cfg;

	// input stage
	logic valid_s1;
	logic [7:0] char_s1;

	// character decode and result queue
	logic adv;
	logic [1:0] nres;
	res_t res0, res1, head;
	logic [1:0] q_cnt, q_left;
	logic [2:0] q_need;

	assign pready = 1'b1;

	pel_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Advance the registered character once the queue has room for all of its
	// results, counting the slot that the result side frees this cycle.
	assign q_need = {1'b0, q_left} + {1'b0, nres};
	assign adv = valid_s1 && (q_need <= 3'd2);
	assign rx_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	// hold the character while it waits for queue room
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			char_s1 <= rx_char;
		end
	end

	pel_entry #(
		.MAX_LEN (MAX_LEN)
	) u_entry (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ch     (char_s1),
		.adv    (adv),
		.nres   (nres),
		.res0   (res0),
		.res1   (res1)
	);

	pel_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (adv ? nres : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.pop      (res_ready),
		.valid    (res_valid),
		.head     (head),
		.cnt      (q_cnt),
		.cnt_left (q_left)
	);

	assign result_kind = head.kind;
	assign echo_char = head.echo;
	assign attempts_left = head.left;
	assign last_of_run = head.last;

`ifndef SYNTHESIS
	// queue never overfills
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt <= 2'd2)
		else $error("result queue holds more than two transactions");

	// a backspace pair only goes into a queue that empties this cycle
	a_pair_room: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && nres == 2'd2) |-> (q_left == 2'd0))
		else $error("result pair pushed into an occupied queue");

	// a lone queued result always closes its run
	a_lone_last: assert property (@(posedge clk) disable iff (!arst_n)
		(q_cnt == 2'd1) |-> last_of_run)
		else $error("single queued result is not last of run");
`endif

endmodule

`default_nettype wire

// ===== rtl/pel_regs.sv =====
// APB-style configuration registers of the password entry lockout block.
// Depends on pel_pkg for register indexes, reset values and the cfg_t struct.
`default_nettype none

module pel_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic      [63:0]  prdata,
	output pel_pkg::cfg_t     cfg
);
	import pel_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	reg_idx_t idx;

	assign wr_en = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[4:3]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pw_first8 <= PW_FIRST8_RST;
			cfg_q.pw_last2 <= PW_LAST2_RST;
			cfg_q.pw_len <= PW_LEN_RST;
			cfg_q.max_fail <= MAX_FAIL_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PW_FIRST8: cfg_q.pw_first8 <= pwdata;
				REG_PW_LAST2:  cfg_q.pw_last2 <= pwdata[15:0];
				REG_PW_LEN:    cfg_q.pw_len <= pwdata[3:0];
				REG_MAX_FAIL:  cfg_q.max_fail <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PW_FIRST8: prdata = cfg_q.pw_first8;
			REG_PW_LAST2:  prdata = {48'd0, cfg_q.pw_last2};
			REG_PW_LEN:    prdata = {60'd0, cfg_q.pw_len};
			REG_MAX_FAIL:  prdata = {60'd0, cfg_q.max_fail};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pel_entry.sv =====
// Entry buffer, failure counter and mode of the password entry lockout block.
// Decides the results of one character and updates state when told to advance.
// Depends on pel_pkg.
`default_nettype none

module pel_entry #(
	parameter int MAX_LEN = 10
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pel_pkg::cfg_t  cfg,
	input  wire logic [7:0]     ch,
	input  wire logic           adv,
	output logic      [1:0]     nres,
	output pel_pkg::res_t       res0,
	output pel_pkg::res_t       res1
);
	import pel_pkg::*;

	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic [7:0] buf_q [MAX_LEN];
	logic [CNT_W-1:0] count_q, count_d;
	logic [FAIL_W-1:0] fail_q, fail_d, fail_inc;
	mode_t mode_q, mode_d;

	logic [8*PW_CHARS-1:0] pw;
	logic mism, match, store;
	logic [3:0] acc_left;

	assign pw = {cfg.pw_last2, cfg.pw_first8};

	// Compare every stored position below the count against the password.
	always_comb begin
		mism = 1'b0;
		for (int k = 0; k < MAX_LEN; k++) begin
			if (CNT_W'(k) < count_q && buf_q[k] != pw[8*k +: 8]) begin
				mism = 1'b1;
			end
		end
	end

	assign match = (cfg.pw_len <= CNT_W'(MAX_LEN)) && (count_q == cfg.pw_len) && !mism;
	assign fail_inc = (fail_q != FAIL_SAT) ? fail_q + 4'd1 : fail_q;
	assign acc_left = (fail_q < cfg.max_fail) ? cfg.max_fail - fail_q : 4'd0;

	always_comb begin
		mode_d = mode_q;
		count_d = count_q;
		fail_d = fail_q;
		store = 1'b0;
		nres = 2'd0;
		res0 = '0;
		res1 = '0;
		unique case (mode_q)
			MODE_ENTERING: begin
				if (ch == CH_BACKSPACE) begin
					if (count_q != '0) begin
						count_d = count_q - 4'd1;
						nres = 2'd2;
						res0 = '{kind: KIND_ECHO, echo: CH_BACKSPACE, left: 4'd0, last: 1'b0};
						res1 = '{kind: KIND_ECHO, echo: CH_NUL, left: 4'd0, last: 1'b1};
					end
				end else if (ch == CH_ENTER) begin
					count_d = '0;
					nres = 2'd1;
					if (match) begin
						mode_d = MODE_OPEN;
						res0 = '{kind: KIND_ACCEPT, echo: CH_NUL, left: acc_left, last: 1'b1};
					end else begin
						fail_d = fail_inc;
						if (fail_inc >= cfg.max_fail) begin
							mode_d = MODE_LOCKED;
							res0 = '{kind: KIND_LOCKED, echo: CH_NUL, left: 4'd0, last: 1'b1};
						end else begin
							res0 = '{kind: KIND_REJECT, echo: CH_NUL,
								left: cfg.max_fail - fail_inc, last: 1'b1};
						end
					end
				end else if (count_q < CNT_W'(MAX_LEN)) begin
					store = 1'b1;
					count_d = count_q + 4'd1;
					nres = 2'd1;
					res0 = '{kind: KIND_ECHO, echo: CH_STAR, left: 4'd0, last: 1'b1};
				end
			end
			// open, locked and the unused code ignore all input
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENTERING;
			count_q <= '0;
			fail_q <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			count_q <= count_d;
			fail_q <= fail_d;
		end
	end

	// Positions at or above the count are never compared, so no clearing is needed.
	always_ff @(posedge clk) begin
		if (adv && store) begin
			buf_q[count_q[IDX_W-1:0]] <= ch;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pel_outq.sv =====
// Two-entry result queue of the password entry lockout block.
// Takes up to two results at once and presents them in order. Depends on pel_pkg.
`default_nettype none

module pel_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     push_n,
	input  wire pel_pkg::res_t  push0,
	input  wire pel_pkg::res_t  push1,
	input  wire logic           pop,
	output logic                valid,
	output pel_pkg::res_t       head,
	output logic      [1:0]     cnt,
	output logic      [1:0]     cnt_left
);
	import pel_pkg::*;

	res_t slot0_q, slot1_q, keep0;
	logic [1:0] cnt_q;

	assign cnt = cnt_q;
	assign valid = (cnt_q != 2'd0);
	assign head = slot0_q;
	// occupancy once the head leaves this cycle
	assign cnt_left = cnt_q - {1'b0, pop && valid};
	assign keep0 = (pop && valid) ? slot1_q : slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_left + push_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_left == 2'd0) begin
			slot0_q <= push0;
			slot1_q <= push1;
		end else begin
			slot0_q <= keep0;
			if (push_n != 2'd0) begin
				slot1_q <= push0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/password_lock_checker.sv =====
// Response checker for the password entry lockout block.
// Snoops the register port and both streams, predicts responses, counts mismatches.
// Depends on pel_pkg for codes, reset values and the response type.
module password_lock_checker #(
	parameter int MAX_LEN = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  logic [7:0]  rx_char,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  echo_char,
	input  logic [3:0]  attempts_left,
	input  logic        last_of_run,
	output int          pending_results,
	output int          mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import pel_pkg::*;

	cfg_t       lock_cfg;
	logic [7:0] entry_buf [PW_CHARS];
	logic [3:0] entry_len;
	logic [3:0] fail_tally;
	mode_t      lock_mode;
	res_t       expected_responses [$];
	int         mismatches = 0;

	function automatic res_t make_response(input kind_t kind, input logic [7:0] echo,
			input logic [3:0] left, input logic last);
		res_t r;
		r.kind = kind;
		r.echo = echo;
		r.left = left;
		r.last = last;
		return r;
	endfunction

	function automatic logic [7:0] password_byte(input int k);
		if (k < 8)
			return lock_cfg.pw_first8[8*k +: 8];
		return lock_cfg.pw_last2[8*(k-8) +: 8];
	endfunction

	// An entry opens the lock only on an exact length and byte match.
	function automatic logic entry_opens_lock();
		int k;
		if (lock_cfg.pw_len > MAX_LEN || entry_len != lock_cfg.pw_len)
			return 1'b0;
		for (k = 0; k < entry_len; k++)
			if (entry_buf[k] != password_byte(k))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic predict_lock_response(input logic [7:0] ch);
		logic opens;
		int k;
		// Open and locked modes swallow everything.
		if (lock_mode != MODE_ENTERING)
			return;
		if (ch == CH_BACKSPACE) begin
			if (entry_len == 0)
				return;
			entry_len--;
			entry_buf[entry_len] = CH_NUL;
			expected_responses.push_back(make_response(KIND_ECHO, CH_BACKSPACE, 4'd0, 1'b0));
			expected_responses.push_back(make_response(KIND_ECHO, CH_NUL, 4'd0, 1'b1));
		end else if (ch == CH_ENTER) begin
			opens = entry_opens_lock();
			for (k = 0; k < PW_CHARS; k++)
				entry_buf[k] = CH_NUL;
			entry_len = 0;
			if (opens) begin
				lock_mode = MODE_OPEN;
				expected_responses.push_back(make_response(KIND_ACCEPT, CH_NUL,
					(fail_tally < lock_cfg.max_fail) ? lock_cfg.max_fail - fail_tally : 4'd0,
					1'b1));
			end else begin
				if (fail_tally != FAIL_SAT)
					fail_tally++;
				if (fail_tally >= lock_cfg.max_fail) begin
					lock_mode = MODE_LOCKED;
					expected_responses.push_back(make_response(KIND_LOCKED, CH_NUL, 4'd0, 1'b1));
				end else begin
					expected_responses.push_back(make_response(KIND_REJECT, CH_NUL,
						lock_cfg.max_fail - fail_tally, 1'b1));
				end
			end
		end else if (entry_len < MAX_LEN) begin
			entry_buf[entry_len] = ch;
			entry_len++;
			expected_responses.push_back(make_response(KIND_ECHO, CH_STAR, 4'd0, 1'b1));
		end
	endtask

	task automatic check_response();
		res_t want;
		if (expected_responses.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d echo %02h left %0d last %0b",
				result_kind, echo_char, attempts_left, last_of_run));
			return;
		end
		want = expected_responses.pop_front();
		if (result_kind !== want.kind || echo_char !== want.echo ||
				attempts_left !== want.left || last_of_run !== want.last)
			report_mismatch($sformatf(
				"got kind %0d echo %02h left %0d last %0b, want kind %0d echo %02h left %0d last %0b",
				result_kind, echo_char, attempts_left, last_of_run,
				want.kind, want.echo, want.left, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_cfg = '{PW_FIRST8_RST, PW_LAST2_RST, PW_LEN_RST, MAX_FAIL_RST};
			for (int k = 0; k < PW_CHARS; k++)
				entry_buf[k] = CH_NUL;
			entry_len = 0;
			fail_tally = 0;
			lock_mode = MODE_ENTERING;
			expected_responses.delete();
			pending_results <= 0;
			mismatch_count <= mismatches;
		end else begin
			if (res_valid && res_ready)
				check_response();
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:3]))
					REG_PW_FIRST8: lock_cfg.pw_first8 = pwdata;
					REG_PW_LAST2:  lock_cfg.pw_last2 = pwdata[15:0];
					REG_PW_LEN:    lock_cfg.pw_len = pwdata[3:0];
					REG_MAX_FAIL:  lock_cfg.max_fail = pwdata[3:0];
					default: ;
				endcase
			end
			if (rx_valid && rx_ready)
				predict_lock_response(rx_char);
			pending_results <= expected_responses.size();
			mismatch_count <= mismatches;
		end
	end

endmodule

// ===== tb/tb_password_entry_lockout.sv =====
// Top of the password entry lockout testbench: clock, reset, register writes,
// character stimulus, result-side back-pressure and the final verdict.
// Depends on pel_pkg, password_entry_lockout and password_lock_checker.
module tb_password_entry_lockout;
	timeunit 1ns;
	timeprecision 1ps;
	import pel_pkg::*;

	localparam int RUN_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int PHASES = 8;
	localparam int SETTLE = 6;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        rx_valid;
	logic        rx_ready;
	logic [7:0]  rx_char;
	logic        res_valid;
	logic        res_ready = 1'b1;
	logic [1:0]  result_kind;
	logic [7:0]  echo_char;
	logic [3:0]  attempts_left;
	logic        last_of_run;
	int          pending_results;
	int          mismatch_count;

	// Idling knobs: per-phase percentages, and a switch that kills all idling.
	bit          quiet;
	int          gap_pct;
	int          stall_pct;

	// Stimulus bookkeeping: what the password is and what has been typed so far.
	// Used only to steer the stimulus, never to judge the block.
	logic [7:0]  cur_pw [PW_CHARS];
	int          cur_len;
	int          cur_maxf;
	logic [7:0]  typed_buf [PW_CHARS];
	int          typed_len;
	int          fails;
	int          verdicts;
	int          items_sent;
	int          cycle_count;

	password_entry_lockout #(.MAX_LEN(10)) u_top (.*);

	password_lock_checker #(.MAX_LEN(10)) u_checker (.*);

	always #6 clk = ~clk;

	// Drop res_ready in random bursts; hold it high otherwise.
	always @(posedge clk) begin
		if (!quiet && arst_n && $urandom_range(0, 99) < stall_pct) begin
			res_ready <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		res_ready <= 1'b1;
	end

	// Watchdog: end the run if it stalls.
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL password_entry_lockout");
		$finish;
	end

	// Keep ordinary characters away from the two control codes.
	function automatic logic [7:0] plain_char(input logic [7:0] b);
		return (b == CH_BACKSPACE || b == CH_ENTER) ? b ^ 8'h40 : b;
	endfunction

	function automatic bit entry_would_open();
		int k;
		if (cur_len > 10 || typed_len != cur_len)
			return 1'b0;
		for (k = 0; k < typed_len; k++)
			if (typed_buf[k] != cur_pw[k])
				return 1'b0;
		return 1'b1;
	endfunction

	// Send one character transaction. Call at a rising edge; returns at the
	// edge that accepted it, with valid still high so a back-to-back send
	// needs only one assignment in that step.
	task automatic send_byte(input logic [7:0] ch);
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_char <= ch;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		items_sent++;
		// Track the entry the way a user would see it.
		if (ch == CH_BACKSPACE) begin
			if (typed_len > 0)
				typed_len--;
		end else if (ch == CH_ENTER) begin
			typed_len = 0;
		end else if (typed_len < 10) begin
			typed_buf[typed_len] = ch;
			typed_len++;
		end
	endtask

	// Drop valid and wait until every predicted result has been seen, then
	// let the pipeline settle so nothing is still in flight.
	task automatic drain_results();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write: setup, then access until pready. Drop psel before returning
	// so a following write never re-asserts psel in the same step.
	task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write all four registers from the bookkeeping copy; narrow registers
	// get junk in their upper bits, which the block must ignore.
	task automatic load_password();
		logic [63:0] first8;
		int k;
		for (k = 0; k < 8; k++)
			first8[8*k +: 8] = cur_pw[k];
		reg_write(REG_PW_FIRST8, first8);
		reg_write(REG_PW_LAST2, {32'($urandom), 16'($urandom), cur_pw[9], cur_pw[8]});
		reg_write(REG_PW_LEN, {32'($urandom), 28'($urandom), 4'(cur_len)});
		reg_write(REG_MAX_FAIL, {32'($urandom), 28'($urandom), 4'(cur_maxf)});
	endtask

	// One login attempt: mostly the password with slips and corrections,
	// sometimes random text or raw noise. End it with enter now and then
	// (always as a miss, so the lock stays usable), else mostly erase the entry.
	task automatic run_attempt();
		int style;
		int n;
		int k;
		int slip;
		logic [7:0] ch;
		style = $urandom_range(0, 9);
		if (style <= 5) begin
			n = ((cur_len > 10) ? 10 : cur_len) + $urandom_range(0, 2) - 1;
			slip = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : -1;
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 7) == 0) begin
					send_byte(plain_char(8'($urandom)));
					send_byte(CH_BACKSPACE);
				end
				ch = (k < 10) ? cur_pw[k] : 8'($urandom);
				if (k == slip)
					ch = ch ^ 8'($urandom_range(1, 255));
				send_byte(plain_char(ch));
			end
		end else if (style <= 8) begin
			n = $urandom_range(0, 13);
			for (k = 0; k < n; k++)
				send_byte(plain_char(8'($urandom)));
		end else begin
			n = $urandom_range(1, 20);
			for (k = 0; k < n; k++) begin
				ch = 8'($urandom);
				if (ch == CH_ENTER)
					ch = CH_BACKSPACE;
				send_byte(ch);
			end
		end
		if ($urandom_range(0, 7) == 0 && fails + 2 <= cur_maxf) begin
			// Spoil a matching entry so the verdict is a plain reject.
			if (entry_would_open())
				send_byte(typed_len < 10 ? plain_char(8'($urandom)) : CH_BACKSPACE);
			send_byte(CH_ENTER);
			fails++;
			verdicts++;
		end else if ($urandom_range(0, 3) != 0) begin
			n = typed_len + $urandom_range(0, 2);
			for (k = 0; k < n; k++)
				send_byte(CH_BACKSPACE);
		end
	endtask

	initial begin
		int p;
		int k;
		int n;
		int phase_end;
		bit finish_open;

		// Drive every input to a known value from time zero.
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_valid = 1'b0;
		rx_char = '0;
		quiet = 1'b0;
		gap_pct = 25;
		stall_pct = 25;
		for (k = 0; k < 8; k++)
			cur_pw[k] = PW_FIRST8_RST[8*k +: 8];
		cur_pw[8] = PW_LAST2_RST[7:0];
		cur_pw[9] = PW_LAST2_RST[15:8];
		cur_len = PW_LEN_RST;
		cur_maxf = MAX_FAIL_RST;
		typed_len = 0;
		fails = 0;
		verdicts = 0;
		items_sent = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening on the reset registers: backspace on an empty
		// entry, byte extremes, a full buffer dropping characters, erasing,
		// two rejects (wrong length, empty entry) and bytes next to the
		// control codes. Two rejects leave one try under the default limit.
		send_byte(CH_BACKSPACE);
		send_byte(CH_NUL);
		send_byte(8'hFF);
		send_byte(CH_STAR);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h20);
		send_byte(8'h41);
		send_byte(8'hC3);
		send_byte(CH_BACKSPACE);
		send_byte(CH_BACKSPACE);
		send_byte(CH_ENTER);
		send_byte(CH_ENTER);
		fails = 2;
		verdicts = 2;
		send_byte(8'h76);
		send_byte(CH_BACKSPACE);
		send_byte(CH_BACKSPACE);
		send_byte(8'h09);
		send_byte(8'h0C);
		send_byte(8'h0E);
		send_byte(8'h07);
		drain_results();

		// Random phases, each with its own password, length, limit and idling.
		// Every phase boundary also holds the sender until all results are in.
		for (p = 0; p < PHASES; p++) begin
			for (k = 0; k < PW_CHARS; k++) begin
				case (p)
					0: cur_pw[k] = 8'h00;
					1: cur_pw[k] = 8'hFF;
					2: cur_pw[k] = 8'($urandom);
					default: cur_pw[k] = plain_char(8'($urandom));
				endcase
			end
			case (p)
				0: cur_len = 10;
				1: cur_len = 0;
				2: cur_len = 15;
				3: cur_len = 10;
				default: cur_len = $urandom_range(0, 15);
			endcase
			// Keep the limit within four bits even after many rejects.
			cur_maxf = (p == 0) ? 15 :
				$urandom_range((fails + 2 > 15) ? 15 : fails + 2, 15);
			load_password();
			gap_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 40);
			stall_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 40);
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end)
				run_attempt();
			drain_results();
		end

		// Closing phase, no idling: reach one terminal mode, picked at random.
		quiet = 1'b1;
		finish_open = $urandom_range(0, 1);
		if (finish_open) begin
			// Fresh typeable password, possibly empty; the limit may sit below
			// the failure count so the attempts left clamp at zero.
			cur_len = $urandom_range(0, 10);
			for (k = 0; k < PW_CHARS; k++)
				cur_pw[k] = plain_char(8'($urandom));
			cur_maxf = $urandom_range(0, 15);
			load_password();
			n = typed_len;
			for (k = 0; k < n; k++)
				send_byte(CH_BACKSPACE);
			for (k = 0; k < cur_len; k++)
				send_byte(cur_pw[k]);
			send_byte(CH_ENTER);
		end else begin
			// Pull the limit down to the next failure or below, zero included.
			cur_maxf = $urandom_range(0, fails + 1);
			reg_write(REG_MAX_FAIL, 64'(cur_maxf));
			repeat ($urandom_range(0, 4)) send_byte(plain_char(8'($urandom)));
			if (entry_would_open())
				send_byte(typed_len < 10 ? plain_char(8'($urandom)) : CH_BACKSPACE);
			send_byte(CH_ENTER);
		end
		verdicts++;

		// The block is now open or locked: everything must be swallowed,
		// also after a register write.
		repeat (16) send_byte(8'($urandom));
		send_byte(CH_ENTER);
		send_byte(CH_BACKSPACE);
		drain_results();
		reg_write(REG_MAX_FAIL, 64'd15);
		repeat (8) send_byte(8'($urandom));
		send_byte(CH_ENTER);
		drain_results();

		$display("Covered %0d characters and %0d verdicts over %0d register setups,",
			items_sent, verdicts, PHASES + 2);
		$display("ending in %s with %0d mismatches.",
			finish_open ? "an accepted entry" : "a lockout", mismatch_count);
		if (mismatch_count == 0)
			$display("PASS password_entry_lockout");
		else
			$display("FAIL password_entry_lockout");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pel_pkg.sv
rtl/pel_regs.sv
rtl/pel_entry.sv
rtl/pel_outq.sv
rtl/password_entry_lockout.sv
tb/password_lock_checker.sv
tb/tb_password_entry_lockout.sv
